// ===== rtl/utg_pkg.sv =====
package utg_pkg;

  typedef enum logic [1:0] {
    StatusOk    = 2'd0,
    StatusRange = 2'd1,
    StatusEarly = 2'd2
  } status_e;

  localparam int YearFirst   = 1970;
  localparam int YearLast    = 2099;
  localparam int SecPerDay   = 86400;
  localparam int SecPerHour  = 3600;
  localparam int SecPerMin   = 60;
  localparam int SecPerWeek  = 604800;
  localparam int MsPerSec    = 1000;
  localparam int DaysPerYear = 365;

  // Reciprocal multipliers: floor(x / 1000) for x < 2^16, floor(x / 7) for x < 2^16
  localparam int SecRecip    = 67109;
  localparam int SecShift    = 26;
  localparam int Div7Recip   = 74899;
  localparam int Div7Shift   = 19;

  localparam int LeapEntries = 18;

  // Newest entry first: start year, start month, GPS minus UTC in seconds
  localparam int LeapYear [LeapEntries] = '{
    2017, 2015, 2012, 2009, 2006, 1999, 1997, 1996, 1994,
    1993, 1992, 1991, 1990, 1988, 1985, 1983, 1982, 1981
  };
  localparam int LeapMonth [LeapEntries] = '{
    1, 7, 7, 1, 1, 1, 7, 1, 7,
    7, 7, 1, 1, 1, 7, 7, 7, 7
  };
  localparam int LeapOffset [LeapEntries] = '{
    18, 17, 16, 15, 14, 13, 12, 11, 10,
    9, 8, 7, 6, 5, 4, 3, 2, 1
  };

  // Day of year of the first of each month in a common year
  function automatic logic [8:0] first_day(input logic [3:0] month);
    logic [8:0] fd;
    case (month)
      4'd1:    fd = 9'd1;
      4'd2:    fd = 9'd32;
      4'd3:    fd = 9'd60;
      4'd4:    fd = 9'd91;
      4'd5:    fd = 9'd121;
      4'd6:    fd = 9'd152;
      4'd7:    fd = 9'd182;
      4'd8:    fd = 9'd213;
      4'd9:    fd = 9'd244;
      4'd10:   fd = 9'd274;
      4'd11:   fd = 9'd305;
      4'd12:   fd = 9'd335;
      default: fd = 9'd0;
    endcase
    return fd;
  endfunction

  // Days since 1970-01-01, plus two, for constant dates
  function automatic int day_index_p2(input int y, input int m, input int d);
    int leap;
    leap = ((y % 4 == 0) && (m >= 3)) ? 1 : 0;
    return (y - YearFirst) * DaysPerYear + (y - 1969) / 4
           + int'(first_day(4'(m))) + d + leap;
  endfunction

  localparam int GpsEpochDayP2 = day_index_p2(1980, 1, 6);

endpackage

// ===== rtl/utc_to_gps_week_tow.sv =====
// UTC calendar time to GPS week number and time of week.
//
// Input channel (in_valid_i / in_ready_o) carries one UTC date and time per
// transfer; output channel (out_valid_o / out_ready_i) returns gps_week_o,
// tow_ms_o and status_o for it, one result per input, in order.
// The datapath is a six-register pipeline (input register, four work stages,
// output register), and a new item is taken every cycle while out_ready_i
// does not stall the output: one item per cycle sustained.
// Divisions by 1000 and by 7 are reciprocal multiplies, each followed by a
// register; the leap-second search is a row of parallel day compares.
// Each stage holds its item while the stage after it is full and stalled, so
// a stall on out_ready_i fills the pipeline and then drops in_ready_o; empty
// stages close up so no bubble cycles are lost.
// Status 1 marks a year outside 1970..2099 or a month outside 1..12, status 2
// a time before 1981-07-01; both give week 0 and time of week 0.
// Reset clears all valid bits: the pipeline comes up empty and ready.
module utc_to_gps_week_tow
  import utg_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [11:0] year_i,
  input  logic [3:0]  month_i,
  input  logic [4:0]  day_of_month_i,
  input  logic [4:0]  hour_i,
  input  logic [5:0]  minute_i,
  input  logic [15:0] second_ms_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [12:0] gps_week_o,
  output logic [29:0] tow_ms_o,
  output logic [1:0]  status_o
);

  localparam int Stages = 6;

  logic [Stages-1:0] valid_q, valid_d, stage_en;

  // Stage enables: a stage loads when it is empty or its item moves on
  always_comb begin
    stage_en[Stages-1] = !valid_q[Stages-1] || out_ready_i;
    for (int k = Stages - 2; k >= 0; k--) begin
      stage_en[k] = !valid_q[k] || stage_en[k+1];
    end
  end

  always_comb begin
    valid_d = valid_q;
    if (stage_en[0]) begin
      valid_d[0] = in_valid_i;
    end
    for (int k = 1; k < Stages; k++) begin
      if (stage_en[k]) begin
        valid_d[k] = valid_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  assign in_ready_o  = stage_en[0];
  assign out_valid_o = valid_q[Stages-1];

  // ---------------- stage 1: input register
  logic [11:0] s1_year_q;
  logic [3:0]  s1_month_q;
  logic [4:0]  s1_day_q;
  logic [4:0]  s1_hour_q;
  logic [5:0]  s1_minute_q;
  logic [15:0] s1_sms_q;

  always_ff @(posedge clk_i) begin
    if (stage_en[0] && in_valid_i) begin
      s1_year_q   <= year_i;
      s1_month_q  <= month_i;
      s1_day_q    <= day_of_month_i;
      s1_hour_q   <= hour_i;
      s1_minute_q <= minute_i;
      s1_sms_q    <= second_ms_i;
    end
  end

  // Day count (plus two) since 1970 and whole seconds of second_ms
  logic        s2_bad_d;
  logic [7:0]  year_ofs;
  logic [7:0]  year_ofs_p1;
  logic [15:0] year_days;
  logic        leap_add;
  logic [16:0] s2_dp2_d;
  logic [32:0] sec_prod;
  logic [6:0]  s2_qs_d;

  always_comb begin
    s2_bad_d    = (s1_year_q < 12'(YearFirst)) || (s1_year_q > 12'(YearLast))
                  || (s1_month_q == 4'd0) || (s1_month_q > 4'd12);
    year_ofs    = 8'(s1_year_q - 12'(YearFirst));
    year_ofs_p1 = year_ofs + 8'd1;
    year_days   = 16'(year_ofs) * 16'(DaysPerYear);
    leap_add    = (s1_year_q[1:0] == 2'b00) && (s1_month_q >= 4'd3);
    s2_dp2_d    = 17'(year_days) + 17'(year_ofs_p1 >> 2) + 17'(first_day(s1_month_q))
                  + 17'(s1_day_q) + 17'(leap_add);
    sec_prod    = 33'(s1_sms_q) * 33'(SecRecip);
    s2_qs_d     = 7'(sec_prod >> SecShift);
  end

  // ---------------- stage 2
  logic        s2_bad_q;
  logic [16:0] s2_dp2_q;
  logic [4:0]  s2_hour_q;
  logic [5:0]  s2_minute_q;
  logic [15:0] s2_sms_q;
  logic [6:0]  s2_qs_q;

  always_ff @(posedge clk_i) begin
    if (stage_en[1] && valid_q[0]) begin
      s2_bad_q    <= s2_bad_d;
      s2_dp2_q    <= s2_dp2_d;
      s2_hour_q   <= s1_hour_q;
      s2_minute_q <= s1_minute_q;
      s2_sms_q    <= s1_sms_q;
      s2_qs_q     <= s2_qs_d;
    end
  end

  // Seconds of day, carry a full day into the day count, leap table search
  logic [9:0]  s3_frac_d;
  logic [16:0] sod_raw;
  logic        day_carry;
  logic [16:0] s3_sod_d;
  logic [16:0] day_p2;
  logic        leap_found;
  logic [4:0]  s3_offset_d;
  logic [15:0] s3_dw_d;
  status_e     s3_status_d;

  always_comb begin
    s3_frac_d   = 10'(s2_sms_q - 16'(s2_qs_q) * 16'(MsPerSec));
    sod_raw     = 17'(s2_hour_q) * 17'(SecPerHour) + 17'(s2_minute_q) * 17'(SecPerMin)
                  + 17'(s2_qs_q);
    day_carry   = sod_raw >= 17'(SecPerDay);
    s3_sod_d    = day_carry ? sod_raw - 17'(SecPerDay) : sod_raw;
    day_p2      = s2_dp2_q + 17'(day_carry);
    leap_found  = 1'b0;
    s3_offset_d = '0;
    // Oldest first, so the newest matching entry wins
    for (int i = LeapEntries - 1; i >= 0; i--) begin
      if (day_p2 >= 17'(day_index_p2(LeapYear[i], LeapMonth[i], 1))) begin
        leap_found  = 1'b1;
        s3_offset_d = 5'(LeapOffset[i]);
      end
    end
    s3_dw_d = 16'(day_p2 - 17'(GpsEpochDayP2));
    if (s2_bad_q) begin
      s3_status_d = StatusRange;
    end else if (!leap_found) begin
      s3_status_d = StatusEarly;
    end else begin
      s3_status_d = StatusOk;
    end
  end

  // ---------------- stage 3
  status_e     s3_status_q;
  logic [15:0] s3_dw_q;
  logic [16:0] s3_sod_q;
  logic [4:0]  s3_offset_q;
  logic [9:0]  s3_frac_q;

  always_ff @(posedge clk_i) begin
    if (stage_en[2] && valid_q[1]) begin
      s3_status_q <= s3_status_d;
      s3_dw_q     <= s3_dw_d;
      s3_sod_q    <= s3_sod_d;
      s3_offset_q <= s3_offset_d;
      s3_frac_q   <= s3_frac_d;
    end
  end

  // Whole weeks of the day count
  logic [32:0] div7_prod;
  logic [12:0] s4_q7_d;

  always_comb begin
    div7_prod = 33'(s3_dw_q) * 33'(Div7Recip);
    s4_q7_d   = 13'(div7_prod >> Div7Shift);
  end

  // ---------------- stage 4
  status_e     s4_status_q;
  logic [15:0] s4_dw_q;
  logic [12:0] s4_q7_q;
  logic [16:0] s4_sod_q;
  logic [4:0]  s4_offset_q;
  logic [9:0]  s4_frac_q;

  always_ff @(posedge clk_i) begin
    if (stage_en[3] && valid_q[2]) begin
      s4_status_q <= s3_status_q;
      s4_dw_q     <= s3_dw_q;
      s4_q7_q     <= s4_q7_d;
      s4_sod_q    <= s3_sod_q;
      s4_offset_q <= s3_offset_q;
      s4_frac_q   <= s3_frac_q;
    end
  end

  // Seconds of week; the leap offset may push it into the next week
  logic [2:0]  day_of_week;
  logic [19:0] sow_raw;
  logic        week_wrap;
  logic [19:0] s5_sow_d;
  logic [12:0] s5_week_d;

  always_comb begin
    day_of_week = 3'(s4_dw_q - 16'(s4_q7_q) * 16'd7);
    sow_raw     = 20'(day_of_week) * 20'(SecPerDay) + 20'(s4_sod_q) + 20'(s4_offset_q);
    week_wrap   = sow_raw >= 20'(SecPerWeek);
    s5_sow_d    = week_wrap ? sow_raw - 20'(SecPerWeek) : sow_raw;
    s5_week_d   = s4_q7_q + 13'(week_wrap);
  end

  // ---------------- stage 5
  status_e     s5_status_q;
  logic [12:0] s5_week_q;
  logic [19:0] s5_sow_q;
  logic [9:0]  s5_frac_q;

  always_ff @(posedge clk_i) begin
    if (stage_en[4] && valid_q[3]) begin
      s5_status_q <= s4_status_q;
      s5_week_q   <= s5_week_d;
      s5_sow_q    <= s5_sow_d;
      s5_frac_q   <= s4_frac_q;
    end
  end

  logic [29:0] out_tow_d;
  logic [12:0] out_week_d;

  always_comb begin
    if (s5_status_q == StatusOk) begin
      out_tow_d  = 30'(s5_sow_q) * 30'(MsPerSec) + 30'(s5_frac_q);
      out_week_d = s5_week_q;
    end else begin
      out_tow_d  = '0;
      out_week_d = '0;
    end
  end

  // ---------------- output register
  status_e     out_status_q;
  logic [12:0] out_week_q;
  logic [29:0] out_tow_q;

  always_ff @(posedge clk_i) begin
    if (stage_en[5] && valid_q[4]) begin
      out_status_q <= s5_status_q;
      out_week_q   <= out_week_d;
      out_tow_q    <= out_tow_d;
    end
  end

  assign gps_week_o = out_week_q;
  assign tow_ms_o   = out_tow_q;
  assign status_o   = out_status_q;

endmodule

// ===== dv/tb_utc_to_gps_week_tow.sv =====
module tb_utc_to_gps_week_tow;
  import utg_pkg::*;

  localparam int  LeapRows   = 18;
  localparam int  UnixToGps  = 3657;     // days from 1970-01-01 to 1980-01-06
  localparam longint MsWeek  = 64'd604800000;
  localparam int  MonthStart [12] = '{1, 32, 60, 91, 121, 152, 182, 213, 244, 274, 305, 335};
  // yyyymm of each leap-second step, newest first; GPS-UTC is 18 minus the row
  localparam int  LeapStart [LeapRows] = '{
    201701, 201507, 201207, 200901, 200601, 199901, 199707, 199601, 199407,
    199307, 199207, 199101, 199001, 198801, 198507, 198307, 198207, 198107
  };

  typedef struct packed {
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [15:0] sec_ms;
  } utc_item_t;

  typedef struct packed {
    logic [12:0] week;
    logic [29:0] tow;
    status_e     status;
  } gps_fix_t;

  typedef enum logic [1:0] {RxOpen, RxCoin, RxChoke, RxComb} rx_mode_e;

  class gps_week_tow_board;
    gps_fix_t expected_q[$];
    int       n_bad;

    // Seconds since 1970-01-01; day 0 and days past month end run on linearly
    function automatic longint unix_secs(int y, int m, int d);
      longint days;
      days = longint'(y - 1970) * 365 + (y - 1969) / 4 + MonthStart[m - 1] + d - 2
             + (((y % 4) == 0 && m >= 3) ? 1 : 0);
      return days * 86400;
    endfunction

    function automatic gps_fix_t utc_to_gps(utc_item_t u);
      gps_fix_t r;
      longint   secs, total;
      int       y, m, offset, i;
      bit       found;
      r.week   = '0;
      r.tow    = '0;
      r.status = StatusOk;
      y        = int'(u.year);
      m        = int'(u.month);
      found    = 1'b0;
      offset   = 0;
      if (y < 1970 || y > 2099 || m < 1 || m > 12) begin
        r.status = StatusRange;
      end else begin
        secs = unix_secs(y, m, int'(u.day)) + longint'(u.hour) * 3600
               + longint'(u.minute) * 60 + longint'(u.sec_ms) / 1000;
        // whole seconds only decide the leap step
        for (i = 0; i < LeapRows; i++) begin
          if (!found && secs >= unix_secs(LeapStart[i] / 100, LeapStart[i] % 100, 1)) begin
            found  = 1'b1;
            offset = LeapRows - i;
          end
        end
        if (!found) begin
          r.status = StatusEarly;
        end else begin
          total = (secs + offset - longint'(UnixToGps) * 86400) * 1000
                  + longint'(u.sec_ms) % 1000;
          if (total < 0) total = 0;
          r.week = 13'(total / MsWeek);
          r.tow  = 30'(total % MsWeek);
        end
      end
      return r;
    endfunction

    function void note_input(utc_item_t u);
      expected_q.push_back(utc_to_gps(u));
    endfunction

    function void check_result(logic [12:0] week, logic [29:0] tow, logic [1:0] status);
      gps_fix_t e;
      if (expected_q.size() == 0) begin
        n_bad++;
        if (n_bad <= 10)
          $display("unexpected result: week %0d tow %0d status %0d", week, tow, status);
        return;
      end
      e = expected_q.pop_front();
      if (e.week !== week || e.tow !== tow || e.status !== status) begin
        n_bad++;
        if (n_bad <= 10)
          $display("wrong result: exp week %0d tow %0d status %0d, got week %0d tow %0d status %0d",
                   e.week, e.tow, e.status, week, tow, status);
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [11:0] year_i;
  logic [3:0]  month_i;
  logic [4:0]  day_of_month_i;
  logic [4:0]  hour_i;
  logic [5:0]  minute_i;
  logic [15:0] second_ms_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [12:0] gps_week_o;
  logic [29:0] tow_ms_o;
  logic [1:0]  status_o;

  gps_week_tow_board board = new();

  int       burst_left;
  rx_mode_e rx_mode = RxOpen;
  int       rx_left = 0;
  int       rx_hold = 0;
  int       rx_tick = 0;

  always #5 clk_i = ~clk_i;

  utc_to_gps_week_tow dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .year_i         (year_i),
    .month_i        (month_i),
    .day_of_month_i (day_of_month_i),
    .hour_i         (hour_i),
    .minute_i       (minute_i),
    .second_ms_i    (second_ms_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .gps_week_o     (gps_week_o),
    .tow_ms_o       (tow_ms_o),
    .status_o       (status_o)
  );

  // Receiver: check each transfer, then pick the next ready from a changing stall pattern
  always @(posedge clk_i) begin
    if (out_valid_o === 1'b1 && out_ready_i === 1'b1)
      board.check_result(gps_week_o, tow_ms_o, status_o);
    rx_tick <= rx_tick + 1;
    if (rx_left == 0) begin
      rx_mode <= rx_mode_e'($urandom_range(0, 3));
      rx_left <= $urandom_range(20, 200);
    end else begin
      rx_left <= rx_left - 1;
    end
    case (rx_mode)
      RxOpen: out_ready_i <= 1'b1;
      RxCoin: out_ready_i <= 1'($urandom_range(0, 1));
      RxChoke: begin
        if (rx_hold == 0) begin
          out_ready_i <= 1'b1;
          rx_hold     <= $urandom_range(1, 15);
        end else begin
          out_ready_i <= 1'b0;
          rx_hold     <= rx_hold - 1;
        end
      end
      default: out_ready_i <= (rx_tick % 5) != 0;
    endcase
  end

  // Hold the item until its transfer, then end the burst or keep valid high
  task automatic drive_utc(input utc_item_t u);
    int gap;
    in_valid_i     <= 1'b1;
    year_i         <= u.year;
    month_i        <= u.month;
    day_of_month_i <= u.day;
    hour_i         <= u.hour;
    minute_i       <= u.minute;
    second_ms_i    <= u.sec_ms;
    @(posedge clk_i);
    while (in_ready_o !== 1'b1) @(posedge clk_i);
    board.note_input(u);
    burst_left--;
    if (burst_left <= 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 60);
    end
  endtask

  task automatic drive_date(input int y, input int m, input int d, input int h,
                            input int mi, input int s);
    utc_item_t u;
    u.year   = 12'(y);
    u.month  = 4'(m);
    u.day    = 5'(d);
    u.hour   = 5'(h);
    u.minute = 6'(mi);
    u.sec_ms = 16'(s);
    drive_utc(u);
  endtask

  function automatic utc_item_t random_utc();
    utc_item_t u;
    int        pick, row, ly, lm;
    pick = $urandom_range(0, 99);
    u.year   = 12'($urandom_range(1978, 2099));
    u.month  = 4'($urandom_range(1, 12));
    u.day    = 5'($urandom_range(1, 31));
    u.hour   = 5'($urandom_range(0, 23));
    u.minute = 6'($urandom_range(0, 59));
    u.sec_ms = 16'($urandom_range(0, 60999));
    if (pick >= 60 && pick < 75) begin
      // land right on or just ahead of a leap step
      row = $urandom_range(0, LeapRows - 1);
      ly  = LeapStart[row] / 100;
      lm  = LeapStart[row] % 100;
      u.year  = 12'(ly);
      u.month = 4'(lm);
      case ($urandom_range(0, 2))
        0: begin
          u.day = 5'd1; u.hour = 5'd0; u.minute = 6'd0;
          u.sec_ms = 16'($urandom_range(0, 1999));
        end
        1: begin
          u.day = 5'd0; u.hour = 5'd23; u.minute = 6'd59;
          u.sec_ms = 16'($urandom_range(58000, 60999));
        end
        default: begin
          u.year  = 12'((lm == 1) ? ly - 1 : ly);
          u.month = 4'((lm == 1) ? 12 : 6);
          u.day   = 5'((lm == 1) ? 31 : 30);
          u.hour = 5'd23; u.minute = 6'd59;
          u.sec_ms = 16'($urandom_range(58000, 60999));
        end
      endcase
    end else if (pick >= 75 && pick < 85) begin
      u.year   = 12'($urandom_range(1970, 2099));
      u.day    = 5'($urandom_range(0, 31));
      u.hour   = 5'($urandom_range(0, 31));
      u.minute = 6'($urandom_range(0, 63));
      u.sec_ms = 16'($urandom_range(0, 65535));
    end else if (pick >= 85) begin
      u = utc_item_t'(48'({$urandom, $urandom}));
    end
    return u;
  endfunction

  initial begin
    int k;
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    out_ready_i    = 1'b0;
    year_i         = '0;
    month_i        = '0;
    day_of_month_i = '0;
    hour_i         = '0;
    minute_i       = '0;
    second_ms_i    = '0;
    burst_left     = $urandom_range(1, 60);
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // range errors, all-ones and all-zero fields
    drive_date(1969, 6, 15, 12, 0, 0);
    drive_date(2100, 1, 1, 0, 0, 0);
    drive_date(4095, 15, 31, 31, 63, 65535);
    drive_date(0, 0, 0, 0, 0, 0);
    drive_date(1975, 0, 10, 1, 1, 1000);
    drive_date(2020, 13, 10, 1, 1, 1000);
    // before the first leap step
    drive_date(1970, 1, 1, 0, 0, 0);
    drive_date(1980, 1, 6, 0, 0, 0);
    drive_date(1981, 6, 30, 23, 59, 59999);
    // exactly on a step, and the leap second itself
    drive_date(1981, 7, 1, 0, 0, 0);
    drive_date(2016, 12, 31, 23, 59, 60500);
    drive_date(2017, 1, 1, 0, 0, 0);
    drive_date(2017, 1, 0, 23, 59, 60999);
    drive_date(2005, 12, 31, 23, 59, 60999);
    drive_date(2015, 6, 30, 23, 59, 60000);
    drive_date(2015, 7, 1, 0, 0, 999);
    // leap-year day counting and day overflow
    drive_date(2000, 2, 29, 12, 30, 30500);
    drive_date(2000, 3, 1, 0, 0, 0);
    drive_date(2020, 2, 31, 8, 0, 0);
    drive_date(2023, 4, 31, 0, 0, 1);
    drive_date(2099, 12, 31, 31, 63, 65535);
    drive_date(2099, 1, 1, 0, 0, 0);
    drive_date(2024, 3, 10, 31, 63, 999);

    for (k = 0; k < 1850; k++) drive_utc(random_utc());

    in_valid_i <= 1'b0;
    while (board.expected_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (board.n_bad == 0 && board.expected_q.size() == 0) begin
      $display("utc_to_gps_week_tow: match");
    end else begin
      $display("utc_to_gps_week_tow: mismatch");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("utc_to_gps_week_tow: mismatch");
    $finish;
  end

endmodule
